FILE: rtl/core/cbfd_pkg.sv
// Shared types and constants for the byte-offset image decoder.
`timescale 1ns / 1ps
`default_nettype none

package cbfd_pkg;

  localparam int unsigned CNT_W = 25;

  // data signature that opens the binary section
  localparam logic [7:0] SIG_0 = 8'h0C;
  localparam logic [7:0] SIG_1 = 8'h1A;
  localparam logic [7:0] SIG_2 = 8'h04;
  localparam logic [7:0] SIG_3 = 8'hD5;

  localparam logic [7:0]  ESC_BYTE = 8'h80;
  localparam logic [15:0] ESC_WORD = 16'h8000;

  // decoder phases
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_IDLE   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_PIXEL = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;

  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic [1:0]         status;
    logic               last_pixel;
  } cbfd_result_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = SIG_0;
      2'd1:    b = SIG_1;
      2'd2:    b = SIG_2;
      default: b = SIG_3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbfd_core.sv
// Signature hunt, code decoder and running-value accumulator.
`timescale 1ns / 1ps
`default_nettype none

module cbfd_core
  import cbfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             file_start,
  input  wire logic             file_end,
  input  wire logic [CNT_W-1:0] pixel_count,
  output logic                  res_valid,
  output cbfd_result_t          res
);

  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       sm_r, sm_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [23:0]      shift_r, shift_nxt;
  logic [31:0]      run_r, run_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;

  logic [CNT_W-1:0] cnt_eff;
  logic [31:0]      delta;
  logic [15:0]      word16;
  logic             have_pix;
  logic             last;
  logic             trunc;

  assign cnt_eff = (pixel_count == '0) ? CNT_W'(1) : pixel_count;
  assign word16  = {data_byte, shift_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    sm_nxt    = sm_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    run_nxt   = run_r;
    done_nxt  = done_r;
    delta     = '0;
    have_pix  = 1'b0;
    last      = 1'b0;
    trunc     = 1'b0;

    if (file_start) begin
      phase_nxt = PH_HUNT;
      sm_nxt    = '0;
      idx_nxt   = '0;
      shift_nxt = '0;
      run_nxt   = '0;
      done_nxt  = '0;
    end

    case (phase_nxt)
      PH_HUNT: begin
        if (data_byte == sig_byte(sm_nxt)) begin
          if (sm_nxt == 2'd3) begin
            sm_nxt    = '0;
            phase_nxt = PH_DECODE;
          end else begin
            sm_nxt = sm_nxt + 2'd1;
          end
        end else begin
          sm_nxt = (data_byte == SIG_0) ? 2'd1 : 2'd0;
        end
      end
      PH_DECODE: begin
        case (idx_nxt)
          3'd0: begin
            if (data_byte != ESC_BYTE) begin
              delta    = {{24{data_byte[7]}}, data_byte};
              have_pix = 1'b1;
            end else begin
              shift_nxt = '0;
              idx_nxt   = 3'd1;
            end
          end
          3'd1: begin
            shift_nxt = {16'd0, data_byte};
            idx_nxt   = 3'd2;
          end
          3'd2: begin
            shift_nxt = '0;
            if (word16 != ESC_WORD) begin
              delta    = {{16{word16[15]}}, word16};
              have_pix = 1'b1;
              idx_nxt  = 3'd0;
            end else begin
              idx_nxt = 3'd3;
            end
          end
          3'd3: begin
            shift_nxt[7:0] = data_byte;
            idx_nxt        = 3'd4;
          end
          3'd4: begin
            shift_nxt[15:8] = data_byte;
            idx_nxt         = 3'd5;
          end
          3'd5: begin
            shift_nxt[23:16] = data_byte;
            idx_nxt          = 3'd6;
          end
          default: begin
            // final byte of the 32-bit escape
            delta     = {data_byte, shift_nxt};
            have_pix  = 1'b1;
            idx_nxt   = 3'd0;
            shift_nxt = '0;
          end
        endcase
        if (have_pix) begin
          run_nxt  = run_nxt + delta;
          done_nxt = done_nxt + CNT_W'(1);
          if (done_nxt >= cnt_eff || done_nxt == '0) begin
            last      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: ;
    endcase

    if (file_end) begin
      trunc     = (phase_nxt != PH_IDLE);
      phase_nxt = PH_IDLE;
    end
  end

  assign res_valid = step && (have_pix || trunc);

  always_comb begin
    if (trunc) begin
      res.pixel_value = '0;
      res.status      = ST_TRUNC;
      res.last_pixel  = 1'b0;
    end else begin
      res.pixel_value = run_nxt;
      res.status      = ST_PIXEL;
      res.last_pixel  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sm_r    <= '0;
      idx_r   <= '0;
      shift_r <= '0;
      run_r   <= '0;
      done_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sm_r    <= sm_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      run_r   <= run_nxt;
      done_r  <= done_nxt;
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.last_pixel |=> phase_r == PH_IDLE)
    else $error("last pixel did not close the image");

  a_pixel_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.status == ST_PIXEL |-> phase_r == PH_DECODE && !file_start)
    else $error("pixel emitted outside decode phase");

endmodule

`default_nettype wire

FILE: rtl/core/cbf_byte_offset_decoder.sv
// Top level: byte-offset image decoder with stream ports and a result skid stage.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready    | tdata: data_byte; tuser: file_start;
//          |     |                          | tlast: file_end
//  out_    | out | out_tvalid / out_tready  | tdata: pixel_value; tuser: status;
//          |     |                          | tlast: last_pixel
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_data: pixel_count (always ready)
//
// One byte is taken per cycle while in_tready is high; decode and the single
// 32-bit accumulate add sit between the core state registers and the result
// register, so a result is registered into out_r, or into skid_r while the head waits.
// A two-entry result stage (output register plus skid) keeps in_tready high
// while one result waits; in_tready drops only when both entries are full.
// Synchronous active-low reset returns the decoder to signature hunt and sets
// pixel_count to 1. Bytes before any file_start count as a new file.
`timescale 1ns / 1ps
`default_nettype none

module cbf_byte_offset_decoder
  import cbfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input requests
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]       in_tuser,   // [0] file_start
  input  wire logic             in_tlast,   // file_end
  // results
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,  // [31:0] pixel_value
  output logic [1:0]            out_tuser,  // [1:0] status
  output logic                  out_tlast,  // last_pixel
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data    // pixel_count
);

  logic [CNT_W-1:0] pix_cnt_r;
  logic             step;
  logic             res_valid;
  cbfd_result_t     res;

  cbfd_result_t     out_r;
  logic             out_v_r;
  cbfd_result_t     skid_r;
  logic             skid_v_r;
  logic             pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign step      = in_tvalid && in_tready;
  assign pop       = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      pix_cnt_r <= cfg_data;
    end
  end

  cbfd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_tdata),
    .file_start  (in_tuser[0]),
    .file_end    (in_tlast),
    .pixel_count (pix_cnt_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // two-entry result queue: out_r is the head, skid_r holds the overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (out_v_r && !pop && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.pixel_value;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last_pixel;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while head empty");

  a_trunc_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_TRUNC |-> out_tdata == '0 && !out_tlast)
    else $error("truncation result carries pixel payload");

endmodule

`default_nettype wire
